### hw/rtl/parallel_port_interface_adapter_unit_defines.svh
// ---------------------------------------------------------------------------
// Parallel port interface adapter: assertion macros
// Clocked property checks that vanish when SYNTHESIS is set.
// ---------------------------------------------------------------------------
`ifndef PARALLEL_PORT_INTERFACE_ADAPTER_UNIT_DEFINES_SVH
`define PARALLEL_PORT_INTERFACE_ADAPTER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property at each rising edge, skipped while reset is high
`define PPIA_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ppia assertion failed");
// Check a property at each rising edge, reset included
`define PPIA_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("ppia assertion failed");
`else
`define PPIA_ASSERT(lbl, clk, rst, prop)
`define PPIA_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

### hw/rtl/ppia_pkg.sv
// ---------------------------------------------------------------------------
// Parallel port interface adapter package
// Request codes, register offsets, control bit positions and helpers.
// ---------------------------------------------------------------------------
package ppia_pkg;

  localparam int DATA_W = 8;
  localparam int CTRL_W = 6;

  // Request types
  localparam logic [1:0] REQ_READ  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_LINE  = 2'd2;

  // Register offsets
  localparam logic [1:0] ADDR_PORT_A = 2'd0;
  localparam logic [1:0] ADDR_CTRL_A = 2'd1;
  localparam logic [1:0] ADDR_PORT_B = 2'd2;
  localparam logic [1:0] ADDR_CTRL_B = 2'd3;

  // Control register bit positions
  localparam int C1_RISING_BIT  = 1;
  localparam int OUT_SELECT_BIT = 2;
  localparam int C2_RISING_BIT  = 4;
  localparam int C2_OUTPUT_BIT  = 5;

  // Interrupt flag bit positions
  localparam int FLAG1_BIT = 0;
  localparam int FLAG2_BIT = 1;

  typedef logic [DATA_W-1:0] byte_t;
  typedef logic [CTRL_W-1:0] ctrl_t;
  typedef logic [1:0]        flags_t;

  // Control register as seen on a bus read: flag 1 at bit 7, flag 2 at
  // bit 6 while C2 is an input
  function automatic byte_t ctrl_view(input ctrl_t cr, input flags_t fl);
    byte_t v;
    v      = {2'b00, cr};
    v[7]   = fl[FLAG1_BIT];
    v[6]   = fl[FLAG2_BIT] & ~cr[C2_OUTPUT_BIT];
    return v;
  endfunction

  // Port read: pins where the direction bit is 0, latch where it is 1
  function automatic byte_t port_view(input byte_t pins, input byte_t latch,
                                      input byte_t dir);
    return (pins & ~dir) | (latch & dir);
  endfunction

endpackage

### hw/rtl/parallel_port_interface_adapter_unit.sv
// ---------------------------------------------------------------------------
// Parallel port interface adapter unit
// Two-port adapter with port/direction and control registers per side and
// edge-triggered interrupt flags on the C1/C2 control lines.
// ---------------------------------------------------------------------------
//
//  channel | handshake             | payload
//  --------+-----------------------+---------------------------------------
//  req     | req_valid / req_stall | req_type reg_addr write_data
//          |                       | line_select line_level pins_a pins_b
//  rsp     | rsp_valid / rsp_stall | read_data port_a_written port_a_value
//          |                       | port_b_written port_b_value
//
// One request per cycle while req_stall is low; its response appears in the
// result register in the cycle after it is taken. All register updates happen
// on the request's accepting edge. req_stall is high while the result register
// holds an untaken response and rsp_stall is high, and during reset. Reset
// clears the adapter registers and the response valid, not the response data.
// ---------------------------------------------------------------------------
`include "parallel_port_interface_adapter_unit_defines.svh"

module parallel_port_interface_adapter_unit (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     req_valid,
  output logic                     req_stall,
  input  logic [1:0]               req_type,
  input  logic [1:0]               reg_addr,
  input  logic [ppia_pkg::DATA_W-1:0] write_data,
  input  logic [1:0]               line_select,
  input  logic                     line_level,
  input  logic [ppia_pkg::DATA_W-1:0] pins_a,
  input  logic [ppia_pkg::DATA_W-1:0] pins_b,
  output logic                     rsp_valid,
  input  logic                     rsp_stall,
  output logic [ppia_pkg::DATA_W-1:0] read_data,
  output logic                     port_a_written,
  output logic [ppia_pkg::DATA_W-1:0] port_a_value,
  output logic                     port_b_written,
  output logic [ppia_pkg::DATA_W-1:0] port_b_value
);
  import ppia_pkg::*;

  // Architectural state
  ctrl_t      ctrl_a, ctrl_b;
  byte_t      dir_a, dir_b;
  byte_t      latch_a, latch_b;
  flags_t     flags_a, flags_b;
  logic [3:0] line_levels;

  ctrl_t      ctrl_a_next, ctrl_b_next;
  byte_t      dir_a_next, dir_b_next;
  byte_t      latch_a_next, latch_b_next;
  flags_t     flags_a_next, flags_b_next;
  logic [3:0] line_levels_next;

  byte_t      rd_next;
  logic       wa_next, wb_next;
  logic       accept;

  // Line event decode
  logic       side_b, is_c2, old_level, c2_out, rising, set_flag;
  ctrl_t      line_cr;

  assign req_stall = rst | (rsp_valid & rsp_stall);
  assign accept    = req_valid & ~req_stall;

  assign side_b    = line_select[1];
  assign is_c2     = line_select[0];
  assign line_cr   = side_b ? ctrl_b : ctrl_a;
  assign old_level = line_levels[line_select];
  assign c2_out    = is_c2 & line_cr[C2_OUTPUT_BIT];
  assign rising    = is_c2 ? line_cr[C2_RISING_BIT] : line_cr[C1_RISING_BIT];
  assign set_flag  = (old_level != line_level) & ~c2_out & (line_level == rising);

  // Work out the next state and the response for the request
  always_comb begin
    ctrl_a_next      = ctrl_a;
    ctrl_b_next      = ctrl_b;
    dir_a_next       = dir_a;
    dir_b_next       = dir_b;
    latch_a_next     = latch_a;
    latch_b_next     = latch_b;
    flags_a_next     = flags_a;
    flags_b_next     = flags_b;
    line_levels_next = line_levels;
    rd_next          = '0;
    wa_next          = 1'b0;
    wb_next          = 1'b0;

    case (req_type)
      REQ_READ: begin
        unique case (reg_addr)
          ADDR_PORT_A: begin
            if (ctrl_a[OUT_SELECT_BIT]) begin
              rd_next      = port_view(pins_a, latch_a, dir_a);
              flags_a_next = '0;
            end else begin
              rd_next = dir_a;
            end
          end
          ADDR_CTRL_A: rd_next = ctrl_view(ctrl_a, flags_a);
          ADDR_PORT_B: begin
            if (ctrl_b[OUT_SELECT_BIT]) begin
              rd_next      = port_view(pins_b, latch_b, dir_b);
              flags_b_next = '0;
            end else begin
              rd_next = dir_b;
            end
          end
          ADDR_CTRL_B: rd_next = ctrl_view(ctrl_b, flags_b);
          default: rd_next = '0;
        endcase
      end
      REQ_WRITE: begin
        unique case (reg_addr)
          ADDR_PORT_A: begin
            if (ctrl_a[OUT_SELECT_BIT]) begin
              latch_a_next = write_data;
              wa_next      = 1'b1;
            end else begin
              dir_a_next = write_data;
            end
          end
          ADDR_CTRL_A: ctrl_a_next = write_data[CTRL_W-1:0];
          ADDR_PORT_B: begin
            if (ctrl_b[OUT_SELECT_BIT]) begin
              latch_b_next = write_data;
              wb_next      = 1'b1;
            end else begin
              dir_b_next = write_data;
            end
          end
          ADDR_CTRL_B: ctrl_b_next = write_data[CTRL_W-1:0];
          default: ctrl_b_next = ctrl_b;
        endcase
      end
      REQ_LINE: begin
        // Track the new level unless the line is C2 driven as an output
        if ((old_level != line_level) && !c2_out) begin
          line_levels_next[line_select] = line_level;
        end
        if (set_flag) begin
          if (side_b) begin
            flags_b_next[is_c2 ? FLAG2_BIT : FLAG1_BIT] = 1'b1;
          end else begin
            flags_a_next[is_c2 ? FLAG2_BIT : FLAG1_BIT] = 1'b1;
          end
        end
      end
      default: rd_next = '0;
    endcase
  end

  // Advance state on an accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_a      <= '0;
      ctrl_b      <= '0;
      dir_a       <= '0;
      dir_b       <= '0;
      latch_a     <= '0;
      latch_b     <= '0;
      flags_a     <= '0;
      flags_b     <= '0;
      line_levels <= '0;
    end else if (accept) begin
      ctrl_a      <= ctrl_a_next;
      ctrl_b      <= ctrl_b_next;
      dir_a       <= dir_a_next;
      dir_b       <= dir_b_next;
      latch_a     <= latch_a_next;
      latch_b     <= latch_b_next;
      flags_a     <= flags_a_next;
      flags_b     <= flags_b_next;
      line_levels <= line_levels_next;
    end
  end

  // Result register: load on accept, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      read_data      <= rd_next;
      port_a_written <= wa_next;
      port_b_written <= wb_next;
    end
  end

  // Latches change only with an accepted request, so they track the response
  assign port_a_value = latch_a;
  assign port_b_value = latch_b;

  // Checks
  `PPIA_ASSERT(a_latch_a_write, clk, rst, accept && req_type == REQ_WRITE && reg_addr == ADDR_PORT_A && ctrl_a[OUT_SELECT_BIT] |=> rsp_valid && port_a_written && port_a_value == $past(write_data))
  `PPIA_ASSERT(a_port_a_read_clears, clk, rst, accept && req_type == REQ_READ && reg_addr == ADDR_PORT_A && ctrl_a[OUT_SELECT_BIT] |=> flags_a == 2'b00)
  `PPIA_ASSERT(a_one_latch_written, clk, rst, rsp_valid |-> !(port_a_written && port_b_written))
  `PPIA_ASSERT(a_write_reads_zero, clk, rst, rsp_valid && (port_a_written || port_b_written) |-> read_data == '0)
  `PPIA_ASSERT(a_c2a_output_holds, clk, rst, accept && ctrl_a[C2_OUTPUT_BIT] |=> line_levels[1] == $past(line_levels[1]))
  `PPIA_ASSERT_ALWAYS(a_reset_no_rsp, clk, rst |=> !rsp_valid)

endmodule

### tb/parallel_port_interface_adapter_unit_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Parallel port interface adapter unit testbench
// Drives bus reads, bus writes and control line changes through the request
// channel with random idle gaps and response stalls. A scoreboard keeps its
// own copy of the adapter registers, predicts each response and compares
// the responses in order, field by field.
// ---------------------------------------------------------------------------
module parallel_port_interface_adapter_unit_test;
  import ppia_pkg::*;

  localparam logic [1:0]  REQ_SPARE     = 2'd3;
  localparam int unsigned RANDOM_COUNT  = 1625;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int unsigned DRAIN_CYCLES  = 4;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] addr;
    byte_t      data;
    logic [1:0] line;
    logic       level;
    byte_t      pins_a;
    byte_t      pins_b;
  } port_req_t;

  typedef struct packed {
    byte_t read_data;
    logic  a_written;
    byte_t a_value;
    logic  b_written;
    byte_t b_value;
  } port_rsp_t;

  // Scoreboard: tracks adapter registers and queues predicted responses
  class ppia_scoreboard;
    ctrl_t       ctrl_a, ctrl_b;
    byte_t       dir_a, dir_b;
    byte_t       latch_a, latch_b;
    flags_t      flags_a, flags_b;
    logic [3:0]  line_levels;
    port_rsp_t   predicted_q[$];
    int unsigned mismatch_count;

    function new();
      ctrl_a = '0;
      ctrl_b = '0;
      dir_a = '0;
      dir_b = '0;
      latch_a = '0;
      latch_b = '0;
      flags_a = '0;
      flags_b = '0;
      line_levels = '0;
      mismatch_count = 0;
    endfunction

    // Control byte on a bus read: flag 1 at bit 7, flag 2 at bit 6 unless
    // C2 drives out
    function byte_t status_byte(ctrl_t cr, flags_t fl);
      byte_t v;
      v = {2'b00, cr};
      v[7] = fl[FLAG1_BIT];
      if (!cr[C2_OUTPUT_BIT]) v[6] = fl[FLAG2_BIT];
      return v;
    endfunction

    // Advance the register copy by one request and work out its response
    function port_rsp_t apply_request(port_req_t r);
      port_rsp_t rsp;
      ctrl_t     cr;
      logic      side_b, is_c2, active_level;
      rsp = '0;
      case (r.kind)
        REQ_READ: begin
          case (r.addr)
            ADDR_PORT_A: begin
              if (ctrl_a[OUT_SELECT_BIT]) begin
                rsp.read_data = (r.pins_a & ~dir_a) | (latch_a & dir_a);
                flags_a = '0;
              end else begin
                rsp.read_data = dir_a;
              end
            end
            ADDR_CTRL_A: rsp.read_data = status_byte(ctrl_a, flags_a);
            ADDR_PORT_B: begin
              if (ctrl_b[OUT_SELECT_BIT]) begin
                rsp.read_data = (r.pins_b & ~dir_b) | (latch_b & dir_b);
                flags_b = '0;
              end else begin
                rsp.read_data = dir_b;
              end
            end
            default: rsp.read_data = status_byte(ctrl_b, flags_b);
          endcase
        end
        REQ_WRITE: begin
          case (r.addr)
            ADDR_PORT_A: begin
              if (ctrl_a[OUT_SELECT_BIT]) begin
                latch_a = r.data;
                rsp.a_written = 1'b1;
              end else begin
                dir_a = r.data;
              end
            end
            ADDR_CTRL_A: ctrl_a = r.data[CTRL_W-1:0];
            ADDR_PORT_B: begin
              if (ctrl_b[OUT_SELECT_BIT]) begin
                latch_b = r.data;
                rsp.b_written = 1'b1;
              end else begin
                dir_b = r.data;
              end
            end
            default: ctrl_b = r.data[CTRL_W-1:0];
          endcase
        end
        REQ_LINE: begin
          side_b = r.line[1];
          is_c2 = r.line[0];
          cr = side_b ? ctrl_b : ctrl_a;
          // An edge on C2 driven as output is dropped, level included
          if (line_levels[r.line] != r.level && !(is_c2 && cr[C2_OUTPUT_BIT])) begin
            active_level = is_c2 ? cr[C2_RISING_BIT] : cr[C1_RISING_BIT];
            if (r.level == active_level) begin
              if (side_b) flags_b[is_c2 ? FLAG2_BIT : FLAG1_BIT] = 1'b1;
              else flags_a[is_c2 ? FLAG2_BIT : FLAG1_BIT] = 1'b1;
            end
            line_levels[r.line] = r.level;
          end
        end
        default: ;
      endcase
      rsp.a_value = latch_a;
      rsp.b_value = latch_b;
      return rsp;
    endfunction

    function void note_request(port_req_t r);
      predicted_q.push_back(apply_request(r));
    endfunction

    function int unsigned pending();
      return predicted_q.size();
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      mismatch_count++;
    endtask

    task check_response(port_rsp_t got);
      port_rsp_t exp_rsp;
      if (predicted_q.size() == 0) begin
        report("response with no request outstanding");
        return;
      end
      exp_rsp = predicted_q.pop_front();
      if (got.read_data !== exp_rsp.read_data)
        report($sformatf("read_data got %h want %h", got.read_data, exp_rsp.read_data));
      if (got.a_written !== exp_rsp.a_written)
        report($sformatf("port_a_written got %b want %b", got.a_written, exp_rsp.a_written));
      if (got.a_value !== exp_rsp.a_value)
        report($sformatf("port_a_value got %h want %h", got.a_value, exp_rsp.a_value));
      if (got.b_written !== exp_rsp.b_written)
        report($sformatf("port_b_written got %b want %b", got.b_written, exp_rsp.b_written));
      if (got.b_value !== exp_rsp.b_value)
        report($sformatf("port_b_value got %h want %h", got.b_value, exp_rsp.b_value));
    endtask
  endclass

  logic       clk;
  logic       rst;
  logic       req_valid;
  logic       req_stall;
  logic [1:0] req_type;
  logic [1:0] reg_addr;
  byte_t      write_data;
  logic [1:0] line_select;
  logic       line_level;
  byte_t      pins_a;
  byte_t      pins_b;
  logic       rsp_valid;
  logic       rsp_stall;
  byte_t      read_data;
  logic       port_a_written;
  byte_t      port_a_value;
  logic       port_b_written;
  byte_t      port_b_value;

  ppia_scoreboard sb;
  bit             hold_off_req;
  bit             burst_mode;

  parallel_port_interface_adapter_unit dut (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .req_type       (req_type),
    .reg_addr       (reg_addr),
    .write_data     (write_data),
    .line_select    (line_select),
    .line_level     (line_level),
    .pins_a         (pins_a),
    .pins_b         (pins_b),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .read_data      (read_data),
    .port_a_written (port_a_written),
    .port_a_value   (port_a_value),
    .port_b_written (port_b_written),
    .port_b_value   (port_b_value)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Idle stretch length: mostly none or short, now and then long
  function automatic int unsigned idle_len();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(3, 1);
    if (roll < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic port_req_t make_req(logic [1:0] kind, logic [1:0] addr, byte_t data,
                                         logic [1:0] line, logic level, byte_t pa, byte_t pb);
    port_req_t r;
    r.kind = kind;
    r.addr = addr;
    r.data = data;
    r.line = line;
    r.level = level;
    r.pins_a = pa;
    r.pins_b = pb;
    return r;
  endfunction

  function automatic port_req_t random_req();
    port_req_t   r;
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 35) r.kind = REQ_READ;
    else if (roll < 70) r.kind = REQ_WRITE;
    else if (roll < 95) r.kind = REQ_LINE;
    else r.kind = REQ_SPARE;
    r.addr = 2'($urandom_range(3));
    r.data = 8'($urandom_range(255));
    r.line = 2'($urandom_range(3));
    r.level = 1'($urandom_range(1));
    r.pins_a = 8'($urandom_range(255));
    r.pins_b = 8'($urandom_range(255));
    return r;
  endfunction

  // Offer one request after an optional idle gap and hold it until taken
  task automatic send_req(input port_req_t r);
    int unsigned gap;
    gap = burst_mode ? 0 : idle_len();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid   <= 1'b1;
    req_type    <= r.kind;
    reg_addr    <= r.addr;
    write_data  <= r.data;
    line_select <= r.line;
    line_level  <= r.level;
    pins_a      <= r.pins_a;
    pins_b      <= r.pins_b;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  // Watch both channels at each edge
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall)
        sb.note_request(make_req(req_type, reg_addr, write_data, line_select,
                                 line_level, pins_a, pins_b));
      if (rsp_valid && !rsp_stall)
        sb.check_response({read_data, port_a_written, port_a_value,
                           port_b_written, port_b_value});
    end
  end

  // Response side: random stalls, calm stretches and requested long hold-offs
  initial begin
    int unsigned n;
    rsp_stall <= 1'b0;
    @(negedge rst);
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if ($urandom_range(99) < 5) begin
        rsp_stall <= 1'b0;
        repeat ($urandom_range(150, 40)) @(posedge clk);
      end else begin
        n = idle_len();
        if (n > 0) begin
          rsp_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
      end
      rsp_stall <= 1'b0;
      n = idle_len();
      repeat (n > 0 ? n : 1) @(posedge clk);
    end
  end

  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles", CYCLE_LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin
    sb = new();
    hold_off_req = 1'b0;
    burst_mode = 1'b0;
    rst         <= 1'b1;
    req_valid   <= 1'b0;
    req_type    <= REQ_READ;
    reg_addr    <= ADDR_PORT_A;
    write_data  <= '0;
    line_select <= '0;
    line_level  <= 1'b0;
    pins_a      <= '0;
    pins_b      <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Register reads straight out of reset
    send_req(make_req(REQ_READ, ADDR_PORT_A, 8'h00, 2'd0, 1'b0, 8'hFF, 8'hFF));
    send_req(make_req(REQ_READ, ADDR_CTRL_A, 8'h00, 2'd0, 1'b0, 8'h00, 8'h00));
    send_req(make_req(REQ_READ, ADDR_PORT_B, 8'h00, 2'd0, 1'b0, 8'hFF, 8'hFF));
    send_req(make_req(REQ_READ, ADDR_CTRL_B, 8'h00, 2'd0, 1'b0, 8'h00, 8'h00));
    // Direction registers, then select the latches (upper control bits dropped)
    send_req(make_req(REQ_WRITE, ADDR_PORT_A, 8'hF0, 2'd0, 1'b0, 8'h00, 8'h00));
    send_req(make_req(REQ_WRITE, ADDR_PORT_B, 8'h0F, 2'd0, 1'b0, 8'h00, 8'h00));
    send_req(make_req(REQ_WRITE, ADDR_CTRL_A, 8'h04, 2'd0, 1'b0, 8'h00, 8'h00));
    send_req(make_req(REQ_WRITE, ADDR_CTRL_B, 8'hFF, 2'd0, 1'b0, 8'h00, 8'h00));
    send_req(make_req(REQ_WRITE, ADDR_PORT_A, 8'hFF, 2'd0, 1'b0, 8'h00, 8'h00));
    send_req(make_req(REQ_WRITE, ADDR_PORT_B, 8'hAA, 2'd0, 1'b0, 8'h00, 8'h00));
    // CA1 rising is inactive with falling polarity, falling sets flag 1
    send_req(make_req(REQ_LINE, ADDR_PORT_A, 8'h00, 2'd0, 1'b1, 8'h00, 8'h00));
    send_req(make_req(REQ_LINE, ADDR_PORT_A, 8'h00, 2'd0, 1'b0, 8'h00, 8'h00));
    // CA2 as input: falling edge sets flag 2, repeated level does nothing
    send_req(make_req(REQ_LINE, ADDR_PORT_A, 8'h00, 2'd1, 1'b1, 8'h00, 8'h00));
    send_req(make_req(REQ_LINE, ADDR_PORT_A, 8'h00, 2'd1, 1'b0, 8'h00, 8'h00));
    send_req(make_req(REQ_LINE, ADDR_PORT_A, 8'h00, 2'd1, 1'b0, 8'h00, 8'h00));
    send_req(make_req(REQ_READ, ADDR_CTRL_A, 8'h00, 2'd0, 1'b0, 8'h00, 8'h00));
    // CB2 is an output: edge ignored; CB1 rising polarity sets flag 1
    send_req(make_req(REQ_LINE, ADDR_PORT_A, 8'h00, 2'd3, 1'b1, 8'h00, 8'h00));
    send_req(make_req(REQ_LINE, ADDR_PORT_A, 8'h00, 2'd2, 1'b1, 8'h00, 8'h00));
    send_req(make_req(REQ_READ, ADDR_CTRL_B, 8'h00, 2'd0, 1'b0, 8'h00, 8'h00));
    // Port reads mix pins and latch and clear that side's flags
    send_req(make_req(REQ_READ, ADDR_PORT_A, 8'h00, 2'd0, 1'b0, 8'h5A, 8'h00));
    send_req(make_req(REQ_READ, ADDR_CTRL_A, 8'h00, 2'd0, 1'b0, 8'h00, 8'h00));
    send_req(make_req(REQ_READ, ADDR_PORT_B, 8'h00, 2'd0, 1'b0, 8'h00, 8'hFF));
    send_req(make_req(REQ_READ, ADDR_CTRL_B, 8'h00, 2'd0, 1'b0, 8'h00, 8'h00));
    // Unused request type leaves everything alone
    send_req(make_req(REQ_SPARE, ADDR_PORT_A, 8'hFF, 2'd3, 1'b1, 8'hFF, 8'hFF));
    // Back to the direction register view
    send_req(make_req(REQ_WRITE, ADDR_CTRL_A, 8'h00, 2'd0, 1'b0, 8'h00, 8'h00));
    send_req(make_req(REQ_READ, ADDR_PORT_A, 8'h00, 2'd0, 1'b0, 8'h33, 8'h00));

    // Random traffic with bursts and two long response hold-offs
    for (int unsigned i = 0; i < RANDOM_COUNT; i++) begin
      if (i % 64 == 0) burst_mode = ($urandom_range(99) < 25);
      if (i == 400 || i == 1100) hold_off_req = 1'b1;
      send_req(random_req());
    end
    req_valid <= 1'b0;

    // Drain outstanding responses, then give stray ones a chance to show
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/ppia_pkg.sv
hw/rtl/parallel_port_interface_adapter_unit.sv
tb/parallel_port_interface_adapter_unit_test.sv
